[src/palm_pkg.sv]
// ----------------------------------------------------------------------------
// palm_pkg: shared types and constants for the LSE attention merge
// Holds the item types, fixed-point constants and the exp factor table.
// ----------------------------------------------------------------------------
package palm_pkg;

	// Storage depth of the accumulator and the usable head vector length.
	localparam int MAX_HEAD_DIM = 128;
	localparam int DIM_CAP = (MAX_HEAD_DIM < 128) ? MAX_HEAD_DIM : 128;
	localparam int ACC_AW = (MAX_HEAD_DIM > 1) ? $clog2(MAX_HEAD_DIM) : 1;

	// Depth of the queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	// Fixed-point constants.
	localparam logic signed [23:0] LSE_NEG_INF = 24'sh800000;
	localparam logic signed [23:0] LSE_MAX = 24'sh7FFFFF;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [15:0] LN2_Q16 = 16'd45426;
	localparam logic [30:0] Q30_ONE = 31'h40000000;

	// Register map.
	localparam logic REG_HEAD_DIM = 1'b0;

	typedef struct packed {
		logic signed [23:0] partial_lse;
		logic signed [31:0] value;
		logic [6:0] element_index;
		logic first_partial;
		logic last_partial;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] merged_value;
		logic signed [23:0] out_lse;
		logic [6:0] out_index;
		logic last;
	} out_item_t;

	// Classified element as it waits between front and back.
	typedef struct packed {
		logic signed [23:0] lse;
		logic signed [31:0] value;
		logic [6:0] idx;
		logic first;
		logic emit;
		logic tail;
	} q_item_t;

	// Result of the weight unit.
	typedef struct packed {
		logic done;
		logic [15:0] l;
		logic [16:0] w_hi;
		logic [16:0] w_lo;
	} wres_t;

	// Factors 2^-(2^-i) in Q.30 for i = 1..16.
	typedef logic [16:1][29:0] exp_tab_t;

	function automatic exp_tab_t exp_table();
		logic [63:0] c;
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		exp_tab_t t;
		t = '0;
		c = 64'd1 << 29;
		for (int i = 1; i <= 16; i++) begin
			v = c << 30;
			r = '0;
			b = 64'd1 << 62;
			for (int k = 0; k < 32; k++) begin
				if (b > v) begin
					b = b >> 2;
				end
			end
			for (int k = 0; k < 32; k++) begin
				if (b != 64'd0) begin
					if (v >= r + b) begin
						v = v - (r + b);
						r = (r >> 1) + b;
					end else begin
						r = r >> 1;
					end
					b = b >> 2;
				end
			end
			c = r;
			t[i] = c[29:0];
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = exp_table();

endpackage

[src/partial_attention_lse_merge.sv]
// ----------------------------------------------------------------------------
// partial_attention_lse_merge: log-sum-exp merge of partial attention outputs
// Top level joining the input front, the element queue and the merge engine.
// ----------------------------------------------------------------------------
// Usage:
// Input transfers carry one element of a partial head vector with its
// partial's LSE; elements come in index order. Elements at or beyond the
// configured head length are dropped. Each element of a partial marked last
// yields one output transfer with the merged value and the merged LSE.
// The head length register sits at byte address 0 of the APB port.
// The engine takes one element at a time through the read, multiply and
// write-back sequence on the single accumulator RAM. Element 0 of a partial
// that is merged with two finite LSEs first waits in the weight unit for up
// to four exp/ln passes of 16 multiply steps each.
// A four-entry queue lets input keep arriving while the engine works.
// When the receiver stalls, the result is held in the output register and
// the engine waits before retiring the next emitting element.
// Reset clears the LSE state to minus infinity and the head length to 128;
// accumulator contents are undefined until the first partial writes them.
// ----------------------------------------------------------------------------
module partial_attention_lse_merge (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  palm_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output palm_pkg::out_item_t out_data,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	palm_pkg::q_item_t q_wdata;
	palm_pkg::q_item_t q_rdata;

	assign pready = 1'b1;

	// Front: configuration and element classification.
	palm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.q_full(q_full),
		.q_push(q_push),
		.q_item(q_wdata)
	);

	// Queue between front and back.
	palm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.pop(q_pop),
		.rdata(q_rdata),
		.full(q_full),
		.empty(q_empty)
	);

	// Back: weights, accumulation and output.
	palm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_item(q_rdata),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

[src/palm_ram.sv]
// ----------------------------------------------------------------------------
// palm_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module palm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/palm_queue.sv]
// ----------------------------------------------------------------------------
// palm_queue: short queue between front and back
// A small register FIFO of classified elements.
// ----------------------------------------------------------------------------
module palm_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  palm_pkg::q_item_t wdata,
	input  logic pop,
	output palm_pkg::q_item_t rdata,
	output logic full,
	output logic empty
);

	palm_pkg::q_item_t buf_q [palm_pkg::QDEPTH];
	logic [palm_pkg::QAW-1:0] wr_q;
	logic [palm_pkg::QAW-1:0] rd_q;
	logic [palm_pkg::QAW:0] cnt_q;

	assign full = (cnt_q == (palm_pkg::QAW + 1)'(palm_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = buf_q[rd_q];

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[src/palm_front.sv]
// ----------------------------------------------------------------------------
// palm_front: input side of the merge
// Holds the head length register, drops out-of-range elements and queues
// the rest with their tail flag.
// ----------------------------------------------------------------------------
module palm_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  palm_pkg::in_item_t in_data,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	input  logic q_full,
	output logic q_push,
	output palm_pkg::q_item_t q_item
);

	logic [7:0] head_dim_q;
	logic [7:0] dim;
	logic [7:0] idx_ext;

	// Configuration register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_dim_q <= 8'd128;
		end else if (psel && penable && pwrite && paddr[2] == palm_pkg::REG_HEAD_DIM) begin
			head_dim_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == palm_pkg::REG_HEAD_DIM) ? {24'd0, head_dim_q} : 32'd0;

	// Effective head length, clamped to the supported range.
	always_comb begin
		if (head_dim_q == 8'd0) begin
			dim = 8'd1;
		end else if (head_dim_q > 8'(palm_pkg::DIM_CAP)) begin
			dim = 8'(palm_pkg::DIM_CAP);
		end else begin
			dim = head_dim_q;
		end
	end

	// Classify the element and forward it to the queue.
	assign idx_ext = {1'b0, in_data.element_index};
	assign in_stall = q_full;
	assign q_push = in_valid && !q_full && (idx_ext < dim);

	always_comb begin
		q_item.lse = in_data.partial_lse;
		q_item.value = in_data.value;
		q_item.idx = in_data.element_index;
		q_item.first = in_data.first_partial;
		q_item.emit = in_data.last_partial;
		q_item.tail = (idx_ext == dim - 8'd1);
	end

endmodule

[src/palm_weight.sv]
// ----------------------------------------------------------------------------
// palm_weight: merged LSE offset and merge weights
// Given the LSE gap x, forms l = ln(1 + exp(-x)) and the weights
// exp(-l) and exp(-(x + l)), one multiply step per cycle.
// ----------------------------------------------------------------------------
module palm_weight (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [23:0] x,
	output palm_pkg::wres_t res
);

	localparam logic [2:0] W_IDLE = 3'd0;
	localparam logic [2:0] W_EXPY = 3'd1;
	localparam logic [2:0] W_EXPI = 3'd2;
	localparam logic [2:0] W_EXPE = 3'd3;
	localparam logic [2:0] W_LN = 3'd4;
	localparam logic [2:0] W_LNE = 3'd5;

	// Exponential passes: gap, offset, gap plus offset.
	localparam logic [1:0] PH_GAP = 2'd0;
	localparam logic [1:0] PH_OFS = 2'd2;
	localparam logic [1:0] PH_SUM = 2'd3;

	logic [2:0] state_q;
	logic [1:0] phase_q;
	logic [4:0] cnt_q;
	logic [23:0] x_q;
	logic [15:0] l_q;
	logic [25:0] y_q;
	logic [30:0] p_q;
	logic [30:0] z_q;
	logic [15:0] r_q;
	logic [16:0] w_hi_q;
	logic [16:0] w_lo_q;
	logic done_q;

	logic [24:0] arg;
	logic [41:0] yprod;
	logic [60:0] pprod;
	logic [3:0] ybit;
	logic [30:0] e_res;
	logic [31:0] z0;
	logic [61:0] zsq;
	logic [31:0] zz;
	logic [31:0] lprod;
	logic [31:0] wsum;

	// Datapath of the current step.
	always_comb begin
		case (phase_q)
			PH_OFS: arg = {9'd0, l_q};
			PH_SUM: arg = {1'b0, x_q} + {9'd0, l_q};
			default: arg = {1'b0, x_q};
		endcase
		yprod = 42'(arg) * 42'(palm_pkg::LOG2E_Q16) + 42'd32768;
		pprod = 61'(p_q) * 61'(palm_pkg::EXP_TAB[cnt_q]) + 61'(32'h20000000);
		ybit = 4'(5'd16 - cnt_q);
		e_res = (y_q[25:16] > 10'd30) ? 31'd0 : (p_q >> y_q[20:16]);
		z0 = 32'(palm_pkg::Q30_ONE) + 32'(e_res);
		zsq = 62'(z_q) * 62'(z_q);
		zz = zsq[61:30];
		lprod = 32'(r_q) * 32'(palm_pkg::LN2_Q16) + 32'd32768;
		wsum = 32'(e_res) + 32'd8192;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			phase_q <= PH_GAP;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == W_EXPE) && (phase_q == PH_SUM);
			case (state_q)
				W_IDLE: begin
					if (start) begin
						phase_q <= PH_GAP;
						state_q <= W_EXPY;
					end
				end
				W_EXPY: begin
					cnt_q <= 5'd1;
					state_q <= W_EXPI;
				end
				W_EXPI: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						state_q <= W_EXPE;
					end
				end
				W_EXPE: begin
					case (phase_q)
						PH_GAP: begin
							if (z0[31]) begin
								phase_q <= PH_OFS;
								state_q <= W_EXPY;
							end else begin
								cnt_q <= '0;
								state_q <= W_LN;
							end
						end
						PH_OFS: begin
							phase_q <= PH_SUM;
							state_q <= W_EXPY;
						end
						default: begin
							state_q <= W_IDLE;
						end
					endcase
				end
				W_LN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						state_q <= W_LNE;
					end
				end
				W_LNE: begin
					phase_q <= PH_OFS;
					state_q <= W_EXPY;
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	// Data registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			W_IDLE: begin
				if (start) begin
					x_q <= x;
				end
			end
			W_EXPY: begin
				y_q <= yprod[41:16];
				p_q <= palm_pkg::Q30_ONE;
			end
			W_EXPI: begin
				if (y_q[ybit]) begin
					p_q <= pprod[60:30];
				end
			end
			W_EXPE: begin
				case (phase_q)
					PH_GAP: begin
						z_q <= z0[30:0];
						r_q <= '0;
						if (z0[31]) begin
							l_q <= palm_pkg::LN2_Q16;
						end
					end
					PH_OFS: w_hi_q <= wsum[30:14];
					default: w_lo_q <= wsum[30:14];
				endcase
			end
			W_LN: begin
				if (zz[31]) begin
					z_q <= zz[31:1];
					r_q <= {r_q[14:0], 1'b1};
				end else begin
					z_q <= zz[30:0];
					r_q <= {r_q[14:0], 1'b0};
				end
			end
			W_LNE: begin
				l_q <= lprod[31:16];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.done = done_q;
		res.l = l_q;
		res.w_hi = w_hi_q;
		res.w_lo = w_lo_q;
	end

endmodule

[src/palm_back.sv]
// ----------------------------------------------------------------------------
// palm_back: merge engine
// Takes queued elements one at a time, sets the weights at element 0 of a
// partial, updates the accumulator and emits results of a last partial.
// ----------------------------------------------------------------------------
module palm_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  palm_pkg::q_item_t q_item,
	output logic q_pop,
	output logic out_valid,
	input  logic out_stall,
	output palm_pkg::out_item_t out_data
);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_WAIT = 2'd1;
	localparam logic [1:0] B_MUL = 2'd2;
	localparam logic [1:0] B_SUM = 2'd3;

	logic [1:0] state_q;
	palm_pkg::q_item_t cur_q;
	logic signed [23:0] running_q;
	logic signed [23:0] pend_q;
	logic [16:0] wo_q;
	logic [16:0] wn_q;
	logic old_hi_q;
	logic signed [23:0] hi_q;
	logic signed [49:0] prod_a_s2;
	logic signed [49:0] prod_b_s2;
	logic out_valid_q;
	palm_pkg::out_item_t out_q;

	logic [31:0] acc_rd;
	logic run_inf;
	logic new_inf;
	logic weights_go;
	logic need_w;
	logic old_hi;
	logic [23:0] gap;
	palm_pkg::wres_t wres;
	logic signed [24:0] merged;
	logic signed [50:0] sum;
	logic signed [34:0] rnd;
	logic signed [31:0] sat;
	logic signed [31:0] result;
	logic go;

	palm_ram #(
		.WIDTH(32),
		.DEPTH(palm_pkg::MAX_HEAD_DIM)
	) u_acc (
		.clk(clk),
		.we(state_q == B_SUM && go),
		.waddr(palm_pkg::ACC_AW'(cur_q.idx)),
		.wdata(result),
		.re(q_pop),
		.raddr(palm_pkg::ACC_AW'(q_item.idx)),
		.rdata(acc_rd)
	);

	// Classify the weights needed at the head of a merged partial.
	always_comb begin
		run_inf = (running_q == palm_pkg::LSE_NEG_INF);
		new_inf = (q_item.lse == palm_pkg::LSE_NEG_INF);
		old_hi = (running_q >= q_item.lse);
		gap = old_hi ? 24'(running_q - q_item.lse) : 24'(q_item.lse - running_q);
		q_pop = (state_q == B_IDLE) && !q_empty;
		need_w = q_pop && !q_item.first && (q_item.idx == 7'd0);
		weights_go = need_w && !run_inf && !new_inf;
	end

	palm_weight u_weight (
		.clk(clk),
		.arst_n(arst_n),
		.start(weights_go),
		.x(gap),
		.res(wres)
	);

	// Round, saturate and select the new accumulator value.
	always_comb begin
		merged = 25'(hi_q) + $signed({9'd0, wres.l});
		sum = 51'(prod_a_s2) + 51'(prod_b_s2);
		rnd = 35'((sum + 51'sd32768) >>> 16);
		if (rnd > 35'sd2147483647) begin
			sat = 32'sh7FFFFFFF;
		end else if (rnd < -35'sd2147483648) begin
			sat = 32'sh80000000;
		end else begin
			sat = rnd[31:0];
		end
		result = cur_q.first ? cur_q.value : sat;
		go = !cur_q.emit || !out_valid_q || !out_stall;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			running_q <= palm_pkg::LSE_NEG_INF;
			pend_q <= palm_pkg::LSE_NEG_INF;
			wo_q <= '0;
			wn_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the one just taken; otherwise a taken result clears.
			if (state_q == B_SUM && go && cur_q.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						state_q <= weights_go ? B_WAIT : B_MUL;
						if (q_item.first && q_item.idx == 7'd0) begin
							pend_q <= q_item.lse;
							wo_q <= '0;
							wn_q <= palm_pkg::ONE_Q16;
						end else if (need_w) begin
							if (run_inf && new_inf) begin
								pend_q <= palm_pkg::LSE_NEG_INF;
								wo_q <= palm_pkg::ONE_Q16;
								wn_q <= '0;
							end else if (new_inf) begin
								pend_q <= running_q;
								wo_q <= palm_pkg::ONE_Q16;
								wn_q <= '0;
							end else if (run_inf) begin
								pend_q <= q_item.lse;
								wo_q <= '0;
								wn_q <= palm_pkg::ONE_Q16;
							end
						end
					end
				end
				B_WAIT: begin
					if (wres.done) begin
						pend_q <= (merged > 25'(palm_pkg::LSE_MAX)) ? palm_pkg::LSE_MAX
							: merged[23:0];
						wo_q <= old_hi_q ? wres.w_hi : wres.w_lo;
						wn_q <= old_hi_q ? wres.w_lo : wres.w_hi;
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					state_q <= B_SUM;
				end
				default: begin
					if (go) begin
						if (cur_q.tail) begin
							running_q <= pend_q;
						end
						state_q <= B_IDLE;
					end
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
			old_hi_q <= old_hi;
			hi_q <= old_hi ? running_q : q_item.lse;
		end
		if (state_q == B_MUL) begin
			prod_a_s2 <= $signed(acc_rd) * $signed({1'b0, wo_q});
			prod_b_s2 <= cur_q.value * $signed({1'b0, wn_q});
		end
		if (state_q == B_SUM && go && cur_q.emit) begin
			out_q.merged_value <= result;
			out_q.out_lse <= pend_q;
			out_q.out_index <= cur_q.idx;
			out_q.last <= cur_q.tail;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

[src/palm_checker.sv]
// ----------------------------------------------------------------------------
// palm_checker: port-level checks for the LSE attention merge
// Tracks the head length from APB writes, checks the output hold, indexes and last flag, and the readback.
// ----------------------------------------------------------------------------
module palm_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic out_valid,
	input  logic out_stall,
	input  palm_pkg::out_item_t out_data,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata
);

	logic [7:0] shadow_q;
	logic [7:0] dim;

	// Shadow copy of the head length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_q <= 8'd128;
		end else if (psel && penable && pwrite && paddr[2] == palm_pkg::REG_HEAD_DIM) begin
			shadow_q <= pwdata[7:0];
		end
	end

	always_comb begin
		if (shadow_q == 8'd0) begin
			dim = 8'd1;
		end else if (shadow_q > 8'(palm_pkg::DIM_CAP)) begin
			dim = 8'(palm_pkg::DIM_CAP);
		end else begin
			dim = shadow_q;
		end
	end

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output transfer changed");

	// Every result lies inside the head vector.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, out_data.out_index} < dim))
		else $error("output index beyond head length");

	// The last flag marks exactly the final element.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last == ({1'b0, out_data.out_index} == dim - 8'd1)))
		else $error("last flag does not match final element");

	// A register read returns the written head length.
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && paddr[2] == palm_pkg::REG_HEAD_DIM |-> prdata == {24'd0, shadow_q})
		else $error("head length readback mismatch");

endmodule

bind partial_attention_lse_merge palm_checker u_palm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.paddr(paddr),
	.pwdata(pwdata),
	.prdata(prdata)
);

[dv/partial_attention_lse_merge_chk.sv]
// ----------------------------------------------------------------------------
// partial_attention_lse_merge_chk: result checker for the LSE attention merge
// Watches the input, output and register transfers, predicts each merged
// element from its own fixed-point model and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module partial_attention_lse_merge_chk (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  palm_pkg::in_item_t in_data,
	input  logic out_valid,
	input  logic out_stall,
	input  palm_pkg::out_item_t out_data,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	input  logic pready,
	output int errors,
	output int pending
);
	import palm_pkg::*;

	localparam logic [2:0] ADDR_HEAD_DIM = 3'(4 * REG_HEAD_DIM);

	// Model state of the merge.
	logic signed [31:0] acc_mem [MAX_HEAD_DIM];
	logic signed [23:0] committed_lse;
	logic signed [23:0] cur_lse;
	logic [16:0] w_old;
	logic [16:0] w_new;
	logic [7:0] head_len;
	longint unsigned root_fac [17];
	out_item_t merged_q[$];

	// Integer square root by binary search.
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		lo = 0;
		hi = 64'd1 << 31;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	initial begin
		root_fac[0] = 64'd1 << 29;
		for (int i = 1; i <= 16; i++) root_fac[i] = int_sqrt(root_fac[i - 1] << 30);
	end

	// exp(-x) with x in Q.16, result in Q.30.
	function automatic longint unsigned exp_neg(longint unsigned x);
		longint unsigned y;
		longint unsigned n;
		longint unsigned p;
		y = (x * 94548 + 32768) >> 16;
		n = y >> 16;
		p = 64'd1 << 30;
		if (n > 30) return 0;
		for (int i = 1; i <= 16; i++)
			if (y[16 - i]) p = (p * root_fac[i] + (64'd1 << 29)) >> 30;
		return p >> n;
	endfunction

	// ln(1 + t) with t in Q.30, result in Q.16.
	function automatic longint unsigned log_one_plus(longint unsigned t);
		longint unsigned z;
		longint unsigned r;
		z = (64'd1 << 30) + t;
		r = 0;
		if (z >= (64'd1 << 31)) return 45426;
		for (int i = 0; i < 16; i++) begin
			z = (z * z) >> 30;
			r = r << 1;
			if (z >= (64'd1 << 31)) begin
				z = z >> 1;
				r = r | 1;
			end
		end
		return (r * 45426 + 32768) >> 16;
	endfunction

	function automatic logic [16:0] to_q16(longint unsigned p);
		return 17'((p + 8192) >> 14);
	endfunction

	// Merge the committed LSE with a new partial LSE and derive both weights.
	task automatic merge_weights(logic signed [23:0] old_l, logic signed [23:0] new_l);
		longint hi;
		longint lo;
		longint m;
		longint unsigned x;
		longint unsigned l;
		logic [16:0] w_hi;
		logic [16:0] w_lo;
		logic old_hi;
		if (old_l == LSE_NEG_INF && new_l == LSE_NEG_INF) begin
			cur_lse = LSE_NEG_INF; w_old = ONE_Q16; w_new = '0;
		end else if (new_l == LSE_NEG_INF) begin
			cur_lse = old_l; w_old = ONE_Q16; w_new = '0;
		end else if (old_l == LSE_NEG_INF) begin
			cur_lse = new_l; w_old = '0; w_new = ONE_Q16;
		end else begin
			old_hi = (old_l >= new_l);
			hi = old_hi ? longint'(old_l) : longint'(new_l);
			lo = old_hi ? longint'(new_l) : longint'(old_l);
			x = longint'(hi - lo);
			l = log_one_plus(exp_neg(x));
			m = hi + longint'(l);
			w_hi = to_q16(exp_neg(l));
			w_lo = to_q16(exp_neg(x + l));
			cur_lse = (m > 8388607) ? LSE_MAX : 24'(m);
			w_old = old_hi ? w_hi : w_lo;
			w_new = old_hi ? w_lo : w_hi;
		end
	endtask

	// Weighted multiply-add, rounded half up to Q16.16 and saturated.
	function automatic logic signed [31:0] weighted_sum(logic signed [31:0] a,
			logic signed [31:0] v);
		longint s;
		s = longint'(a) * longint'({47'd0, w_old}) + longint'(v) * longint'({47'd0, w_new});
		s = (s + 32768) >>> 16;
		if (s > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (s < -64'sd2147483648) return 32'sh80000000;
		return 32'(s);
	endfunction

	// Predict on each input transfer, compare on each output transfer.
	always @(posedge clk or negedge arst_n) begin
		int len;
		int nerr;
		out_item_t want;
		out_item_t res;
		if (!arst_n) begin
			committed_lse = LSE_NEG_INF;
			cur_lse = LSE_NEG_INF;
			w_old = '0;
			w_new = '0;
			head_len = 8'd128;
			merged_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			nerr = 0;
			if (psel && penable && pwrite && pready && paddr == ADDR_HEAD_DIM)
				head_len = pwdata[7:0];
			if (out_valid && !out_stall) begin
				if (merged_q.size() == 0) begin
					$error("merged element with none expected: index %0d", out_data.out_index);
					nerr++;
				end else begin
					want = merged_q.pop_front();
					if (out_data.merged_value !== want.merged_value) begin
						$error("merged_value: expected %0d, got %0d",
							want.merged_value, out_data.merged_value);
						nerr++;
					end
					if (out_data.out_lse !== want.out_lse) begin
						$error("out_lse: expected %0d, got %0d",
							want.out_lse, out_data.out_lse);
						nerr++;
					end
					if (out_data.out_index !== want.out_index) begin
						$error("out_index: expected %0d, got %0d",
							want.out_index, out_data.out_index);
						nerr++;
					end
					if (out_data.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, out_data.last);
						nerr++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				len = (head_len < 1) ? 1 : ((head_len > DIM_CAP) ? DIM_CAP : head_len);
				if (in_data.element_index < len) begin
					if (in_data.first_partial) begin
						if (in_data.element_index == 0) begin
							cur_lse = in_data.partial_lse;
							w_old = '0;
							w_new = ONE_Q16;
						end
						acc_mem[in_data.element_index] = in_data.value;
					end else begin
						if (in_data.element_index == 0)
							merge_weights(committed_lse, in_data.partial_lse);
						acc_mem[in_data.element_index] = weighted_sum(
							acc_mem[in_data.element_index], in_data.value);
					end
					if (in_data.element_index == len - 1) committed_lse = cur_lse;
					if (in_data.last_partial) begin
						res.merged_value = acc_mem[in_data.element_index];
						res.out_lse = cur_lse;
						res.out_index = in_data.element_index;
						res.last = (in_data.element_index == len - 1);
						merged_q.push_back(res);
					end
				end
			end
			errors <= errors + nerr;
			pending <= merged_q.size();
		end
	end

endmodule

[dv/partial_attention_lse_merge_tb.sv]
// ----------------------------------------------------------------------------
// partial_attention_lse_merge_tb: testbench top for the LSE attention merge
// Streams directed and random partial head vectors under several head lengths
// with bursty input and a stalling receiver; the checker gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module partial_attention_lse_merge_tb;
	import palm_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 400;
	localparam logic [2:0] ADDR_HEAD_DIM = 3'(4 * REG_HEAD_DIM);

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	int errors;
	int pending;

	// Generator bookkeeping.
	int cycles = 0;
	int sent = 0;
	int burst_left = 0;
	int head_len = 128;
	logic hold_req = 1'b0;
	logic written [MAX_HEAD_DIM];
	logic signed [23:0] base_lse = '0;

	always #4 clk = ~clk;

	partial_attention_lse_merge uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	partial_attention_lse_merge_chk chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
	);

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver stall pattern, with a long hold-off on request.
	initial begin
		int mode;
		out_stall <= 1'b0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end
			if (cycles % 64 == 0) mode = $urandom_range(3);
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(3) == 0);
				2: out_stall <= ($urandom_range(9) < 7);
				default: out_stall <= (cycles % 4 == 0);
			endcase
		end
	end

	// One input transfer, with the burst and gap pattern of the sender.
	task automatic send(logic signed [23:0] lse, logic signed [31:0] val, int idx,
			logic first, logic lastp);
		int gap;
		in_item_t it;
		if (idx < head_len) begin
			// Never merge into an entry that nothing has written yet.
			if (!written[idx]) first = 1'b1;
			if (first) written[idx] = 1'b1;
		end
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		it.partial_lse = lse;
		it.value = val;
		it.element_index = 7'(idx);
		it.first_partial = first;
		it.last_partial = lastp;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Stop sending and let every expected merged element come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_head_len(int d);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_HEAD_DIM;
		pwdata <= 32'(d);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		head_len = d;
	endtask

	function automatic logic signed [23:0] pick_lse();
		int v;
		case ($urandom_range(9))
			0: return LSE_NEG_INF;
			1: return LSE_MAX;
			2: return LSE_NEG_INF + 24'sd1;
			3: return '0;
			4: return 24'($urandom);
			default: begin
				v = int'(base_lse) + $signed($urandom_range(0, 2 << $urandom_range(20)))
					- (1 << $urandom_range(20));
				if (v > 8388607) v = 8388607;
				if (v < -8388607) v = -8388607;
				return 24'(v);
			end
		endcase
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(7))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return 32'($urandom);
			3: return 32'($urandom);
			default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
		endcase
	endfunction

	// A head: a first partial, merged partials, the last one emitting.
	task automatic run_head(int parts);
		logic signed [23:0] lse;
		base_lse = 24'($urandom);
		for (int p = 0; p < parts; p++) begin
			lse = pick_lse();
			for (int i = 0; i < head_len; i++) begin
				// Occasionally drop an element or slip in an out-of-range one.
				if ($urandom_range(49) == 0) continue;
				if (head_len < 128 && $urandom_range(39) == 0)
					send(pick_lse(), pick_value(), $urandom_range(head_len, 127),
						1'($urandom_range(1)), 1'($urandom_range(1)));
				send(lse, pick_value(), i, p == 0, p == parts - 1);
			end
		end
	endtask

	initial begin
		int d;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		for (int i = 0; i < MAX_HEAD_DIM; i++) written[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: minus infinity on both sides, on one side, equal LSEs,
		// merged LSE overflow, far apart LSEs and a missing element 0.
		set_head_len(4);
		send(LSE_NEG_INF, 32'sh7FFFFFFF, 0, 1, 0);
		send(LSE_NEG_INF, 32'sh80000000, 1, 1, 0);
		send(LSE_NEG_INF, 32'sh00010000, 2, 1, 0);
		send(LSE_NEG_INF, -32'sh00010000, 3, 1, 0);
		send(LSE_NEG_INF, 32'sh7FFFFFFF, 0, 0, 1);
		send(LSE_NEG_INF, 32'sh80000000, 3, 0, 1);
		send(24'sh010000, 32'sh7FFFFFFF, 0, 0, 1);
		send(24'sh010000, 32'sh7FFFFFFF, 1, 0, 1);
		send(24'sh010000, 32'sh80000000, 2, 0, 0);
		send(24'sh010000, 32'sh12345678, 3, 0, 1);
		send(24'sh010000, 32'sh7FFFFFFF, 0, 0, 1);
		send(24'sh010000, 32'sh7FFFFFFF, 3, 0, 1);
		send(LSE_MAX, 32'sh80000000, 0, 0, 1);
		send(LSE_MAX, 32'sh7FFFFFFF, 3, 0, 1);
		send(LSE_NEG_INF + 24'sd1, 32'sh7FFFFFFF, 0, 0, 1);
		send(LSE_NEG_INF + 24'sd1, 32'sh00000001, 1, 0, 1);
		send(24'sh000000, 32'sh40000000, 1, 0, 1);
		send(24'sh000000, 32'sh40000000, 3, 0, 1);
		send(24'sh7FFFFF, 32'sh7FFFFFFF, 4, 1, 1);
		send(24'sh555555, 32'shAAAAAAAA, 127, 0, 1);
		send(24'sh2AAAAA, 32'sh55555555, 0, 1, 1);
		send(24'sh2AAAAA, 32'sh55555555, 1, 1, 1);
		send(24'sh2AAAAA, 32'sh55555555, 2, 1, 1);
		send(24'sh2AAAAA, 32'sh55555555, 3, 1, 1);

		// Extreme head lengths.
		set_head_len(1);
		for (int h = 0; h < 12; h++) run_head($urandom_range(1, 4));
		set_head_len(128);
		run_head(2);

		// Long receiver hold-off while the sender keeps offering.
		set_head_len(8);
		hold_req = 1'b1;
		for (int h = 0; h < 4; h++) run_head($urandom_range(1, 4));
		drain();
		for (int h = 0; h < 4; h++) run_head($urandom_range(1, 4));

		// Random phases, mostly short heads.
		while (sent < 820) begin
			case ($urandom_range(5))
				0: d = 1;
				1: d = 2;
				2: d = $urandom_range(3, 8);
				3: d = $urandom_range(9, 20);
				4: d = ($urandom_range(7) == 0) ? 128 : $urandom_range(1, 127);
				default: d = 4;
			endcase
			set_head_len(d);
			for (int h = 0; h < 4 && sent < 820; h++) begin
				if ($urandom_range(5) == 0)
					for (int k = 0; k < 6; k++)
						send(pick_lse(), pick_value(), $urandom_range(127),
							1'($urandom_range(1)), 1'($urandom_range(1)));
				else
					run_head($urandom_range(1, 5));
			end
		end

		drain();
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
src/palm_pkg.sv
src/palm_ram.sv
src/palm_queue.sv
src/palm_front.sv
src/palm_weight.sv
src/palm_back.sv
src/partial_attention_lse_merge.sv
src/palm_checker.sv
dv/partial_attention_lse_merge_chk.sv
dv/partial_attention_lse_merge_tb.sv
